// ===== hdl/pstad_pkg.sv =====
// Package: widths, register indexes, reset values and helpers of the TCP anomaly detector.
`default_nettype none
package pstad_pkg;

    localparam int unsigned SOURCES_DEF    = 32;
    localparam int unsigned PORT_SLOTS_DEF = 32;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned PORT_W    = 16;
    localparam int unsigned PROTO_W   = 8;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CNT_W     = 16;
    localparam int unsigned SHOWN_W   = 6;
    localparam int unsigned PCMP_W    = 9;

    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned IN_USER_W  = 9;
    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned OUT_USER_W = 4;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FLOOD_THR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_THR  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYN_THR   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 8'd3;

    localparam logic [CNT_W-1:0]   FLOOD_THR_RST = 16'd200;
    localparam logic [SHOWN_W-1:0] PORT_THR_RST  = 6'd20;
    localparam logic [CNT_W-1:0]   SYN_THR_RST   = 16'd50;
    localparam logic [TIME_W-1:0]  WINDOW_RST    = 32'd1000;

    localparam logic [PROTO_W-1:0] IPPROTO_TCP = 8'd6;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 16'hFFFF;
    localparam logic [PCMP_W-1:0]  SHOWN_MAX   = 9'd63;

    typedef struct packed {
        logic [TIME_W-1:0] win_start;
        logic [CNT_W-1:0]  pkts;
        logic [CNT_W-1:0]  syns;
        logic [PCMP_W-1:0] ports;
    } entry_rec_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/per_source_tcp_anomaly_detector_unit.sv =====
// Top level: per-source TCP packet, SYN and destination port tracker with alert flags.
//
//  channel   | direction | transaction content
//  s_axis    | in        | tdata: source_address, dest_port, arrival_time; tuser: ip_protocol, syn_flag
//  m_axis    | out       | tdata: source_echo, packets, ports, syns; tuser: alert flags, untracked
//  cfg       | in        | cfg_index, cfg_data; always ready
//
// A TCP packet runs a serial search of the source table, one entry per cycle, then a
// serial scan of the entry's port set, then a write-back of the result.
// A non-TCP packet is accepted while idle and yields no result.
// Reset clears the fill count and the control and configuration registers; the tables need no clearing pass.
// The result register holds while m_axis stalls; the next packet may search meanwhile.
`default_nettype none
module per_source_tcp_anomaly_detector_unit #(
    parameter int unsigned SOURCES    = pstad_pkg::SOURCES_DEF,
    parameter int unsigned PORT_SLOTS = pstad_pkg::PORT_SLOTS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [31:0] source_address, [47:32] dest_port, [79:48] arrival_time
    input  wire logic [pstad_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [7:0] ip_protocol, [8] syn_flag
    input  wire logic [pstad_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [31:0] source_echo, [47:32] packets_in_window, [53:48] distinct_ports,
    // [69:54] syns_in_window, [71:70] zero
    output logic [pstad_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // [0] flood_alert, [1] scan_alert, [2] syn_alert, [3] untracked
    output logic [pstad_pkg::OUT_USER_W-1:0]       m_axis_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pstad_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pstad_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned SRC_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int unsigned FILL_W = $clog2(SOURCES + 1);
    localparam int unsigned PS_W   = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
    localparam int unsigned PC_W   = $clog2(PORT_SLOTS + 1);
    localparam int unsigned PDEPTH = SOURCES * PORT_SLOTS;
    localparam int unsigned PA_W   = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_PSCAN = 3'd4;
    localparam logic [2:0] S_WB    = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [pstad_pkg::CNT_W-1:0]   flood_thr_reg;
    logic [pstad_pkg::SHOWN_W-1:0] port_thr_reg;
    logic [pstad_pkg::CNT_W-1:0]   syn_thr_reg;
    logic [pstad_pkg::TIME_W-1:0]  window_reg;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [SRC_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [SRC_W-1:0]  ent_reg, ent_next;
    logic [PC_W-1:0]   k_reg, k_next;
    logic              untr_reg, untr_next;

    logic [pstad_pkg::ADDR_W-1:0] src_reg, src_next;
    logic [pstad_pkg::PORT_W-1:0] dport_reg, dport_next;
    logic                         syn_reg, syn_next;
    logic [pstad_pkg::TIME_W-1:0] t_reg, t_next;

    logic [pstad_pkg::TIME_W-1:0] ws_reg, ws_next;
    logic [pstad_pkg::CNT_W-1:0]  pkt_reg, pkt_next;
    logic [pstad_pkg::CNT_W-1:0]  sync_reg, sync_next;
    logic [PC_W-1:0]              pc_reg, pc_next;

    logic                             out_valid_reg, out_valid_next;
    logic [pstad_pkg::ADDR_W-1:0]     out_src_reg;
    logic [pstad_pkg::CNT_W-1:0]      out_pkt_reg;
    logic [pstad_pkg::SHOWN_W-1:0]    out_ports_reg;
    logic [pstad_pkg::CNT_W-1:0]      out_syn_reg;
    logic [pstad_pkg::OUT_USER_W-1:0] out_flags_reg;

    logic [pstad_pkg::ADDR_W-1:0] addr_mem [SOURCES];
    logic [pstad_pkg::ADDR_W-1:0] addr_q;
    pstad_pkg::entry_rec_t        rec_mem [SOURCES];
    pstad_pkg::entry_rec_t        rec_q;
    logic [pstad_pkg::PORT_W-1:0] port_mem [PDEPTH];
    logic [pstad_pkg::PORT_W-1:0] port_q;

    logic                      in_fire;
    logic                      src_hit;
    logic                      src_miss;
    logic                      port_hit;
    logic                      port_miss;
    logic                      wb_fire;
    logic                      addr_we;
    logic                      port_we;
    logic [PA_W-1:0]           port_base;
    logic [PA_W-1:0]           port_raddr;
    logic [PA_W-1:0]           port_waddr;
    logic [pstad_pkg::TIME_W-1:0] age;
    logic                      lapse;
    logic [pstad_pkg::PCMP_W-1:0] pc_wide;
    logic [pstad_pkg::SHOWN_W-1:0] shown;
    pstad_pkg::entry_rec_t     wb_rec;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign src_hit   = pend_reg && (addr_q == src_reg);
    assign src_miss  = !src_hit && (idx_reg >= fill_reg);
    assign port_hit  = pend_reg && (port_q == dport_reg);
    assign port_miss = !port_hit && (k_reg >= pc_reg);
    assign wb_fire   = (state_reg == S_WB) && (!out_valid_reg || m_axis_tready);
    assign addr_we   = (state_reg == S_SRCH) && src_miss
                       && (fill_reg != FILL_W'(SOURCES));
    assign port_we   = (state_reg == S_PSCAN) && port_miss
                       && (pc_reg != PC_W'(PORT_SLOTS));

    assign port_base  = PA_W'(ent_reg) * PA_W'(PORT_SLOTS);
    assign port_raddr = port_base + PA_W'(k_reg[PS_W-1:0]);
    assign port_waddr = port_base + PA_W'(pc_reg[PS_W-1:0]);

    assign age   = t_reg - rec_q.win_start;
    assign lapse = (age >= window_reg);

    assign pc_wide = pstad_pkg::PCMP_W'(pc_reg);
    assign shown   = (pc_wide > pstad_pkg::SHOWN_MAX) ? pstad_pkg::SHOWN_W'(pstad_pkg::SHOWN_MAX)
                                                      : pc_wide[pstad_pkg::SHOWN_W-1:0];

    assign wb_rec.win_start = ws_reg;
    assign wb_rec.pkts      = pkt_reg;
    assign wb_rec.syns      = sync_reg;
    assign wb_rec.ports     = pc_wide;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        ent_next      = ent_reg;
        k_next        = k_reg;
        untr_next     = untr_reg;
        src_next      = src_reg;
        dport_next    = dport_reg;
        syn_next      = syn_reg;
        t_next        = t_reg;
        ws_next       = ws_reg;
        pkt_next      = pkt_reg;
        sync_next     = sync_reg;
        pc_next       = pc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (s_axis_tuser[7:0] == pstad_pkg::IPPROTO_TCP))
                begin
                    src_next   = s_axis_tdata[31:0];
                    dport_next = s_axis_tdata[47:32];
                    t_next     = s_axis_tdata[79:48];
                    syn_next   = s_axis_tuser[8];
                    idx_next   = '0;
                    untr_next  = 1'b0;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (src_hit)
                begin
                    ent_next   = pend_idx_reg;
                    state_next = S_LOAD;
                end
                else if (!src_miss)
                begin
                    idx_next      = idx_reg + FILL_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[SRC_W-1:0];
                end
                else if (fill_reg == FILL_W'(SOURCES))
                begin
                    untr_next  = 1'b1;
                    state_next = S_WB;
                end
                else
                begin
                    ent_next   = fill_reg[SRC_W-1:0];
                    fill_next  = fill_reg + FILL_W'(1);
                    ws_next    = t_reg;
                    pkt_next   = pstad_pkg::CNT_W'(1);
                    sync_next  = pstad_pkg::CNT_W'(syn_reg);
                    pc_next    = '0;
                    k_next     = '0;
                    state_next = S_PSCAN;
                end
            end
            S_LOAD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                ws_next    = lapse ? t_reg : rec_q.win_start;
                pkt_next   = pstad_pkg::sat_inc(lapse ? '0 : rec_q.pkts);
                sync_next  = lapse ? pstad_pkg::CNT_W'(syn_reg)
                           : (syn_reg ? pstad_pkg::sat_inc(rec_q.syns) : rec_q.syns);
                pc_next    = lapse ? '0 : rec_q.ports[PC_W-1:0];
                k_next     = '0;
                state_next = S_PSCAN;
            end
            S_PSCAN:
            begin
                if (port_hit)
                begin
                    state_next = S_WB;
                end
                else if (!port_miss)
                begin
                    k_next    = k_reg + PC_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    if (port_we)
                    begin
                        pc_next = pc_reg + PC_W'(1);
                    end
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                if (wb_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (wb_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            k_reg         <= '0;
            untr_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            flood_thr_reg <= pstad_pkg::FLOOD_THR_RST;
            port_thr_reg  <= pstad_pkg::PORT_THR_RST;
            syn_thr_reg   <= pstad_pkg::SYN_THR_RST;
            window_reg    <= pstad_pkg::WINDOW_RST;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            k_reg         <= k_next;
            untr_reg      <= untr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                priority case (cfg_index)
                    pstad_pkg::REG_FLOOD_THR: flood_thr_reg <= cfg_data[15:0];
                    pstad_pkg::REG_PORT_THR:  port_thr_reg  <= cfg_data[5:0];
                    pstad_pkg::REG_SYN_THR:   syn_thr_reg   <= cfg_data[15:0];
                    pstad_pkg::REG_WINDOW:    window_reg    <= cfg_data;
                    default:                  window_reg    <= window_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        ent_reg      <= ent_next;
        src_reg      <= src_next;
        dport_reg    <= dport_next;
        syn_reg      <= syn_next;
        t_reg        <= t_next;
        ws_reg       <= ws_next;
        pkt_reg      <= pkt_next;
        sync_reg     <= sync_next;
        pc_reg       <= pc_next;
        if (wb_fire)
        begin
            out_src_reg <= src_reg;
            if (untr_reg)
            begin
                out_pkt_reg   <= '0;
                out_ports_reg <= '0;
                out_syn_reg   <= '0;
                out_flags_reg <= 4'b1000;
            end
            else
            begin
                out_pkt_reg      <= pkt_reg;
                out_ports_reg    <= shown;
                out_syn_reg      <= sync_reg;
                out_flags_reg[0] <= (pkt_reg > flood_thr_reg);
                out_flags_reg[1] <= (pc_wide > pstad_pkg::PCMP_W'(port_thr_reg));
                out_flags_reg[2] <= (sync_reg > syn_thr_reg);
                out_flags_reg[3] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_q <= addr_mem[idx_reg[SRC_W-1:0]];
        if (addr_we)
        begin
            addr_mem[fill_reg[SRC_W-1:0]] <= src_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_q <= rec_mem[ent_reg];
        if (wb_fire && !untr_reg)
        begin
            rec_mem[ent_reg] <= wb_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        port_q <= port_mem[port_raddr];
        if (port_we)
        begin
            port_mem[port_waddr] <= dport_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_syn_reg, out_ports_reg, out_pkt_reg, out_src_reg};
    assign m_axis_tuser  = out_flags_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(SOURCES))
        else $error("source table fill count beyond table depth");

    a_untracked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |->
            (m_axis_tdata[69:32] == '0 && m_axis_tuser[2:0] == 3'b000))
        else $error("untracked result carries counts or alerts");

    a_tracked_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[3]) |->
            (m_axis_tdata[47:32] != '0 && m_axis_tdata[53:48] != '0))
        else $error("tracked result without packet or port count");

    a_port_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB && !untr_reg) |-> (pc_wide <= pstad_pkg::PCMP_W'(PORT_SLOTS)))
        else $error("port count beyond port slots");

    a_busy_after_tcp: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tuser[7:0] == pstad_pkg::IPPROTO_TCP) |=> (state_reg == S_SRCH))
        else $error("TCP transaction did not start a table search");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench: drives packet headers and register writes into the TCP anomaly detector and checks every result.
module testbench;
    import pstad_pkg::*;

    localparam int unsigned SOURCES       = SOURCES_DEF;
    localparam int unsigned PORT_SLOTS    = PORT_SLOTS_DEF;
    localparam int unsigned POOL_SIZE     = SOURCES + 4;
    localparam int unsigned PHASE_ITEMS   = 130;
    localparam int unsigned SAT_ITEMS     = 65540;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam longint unsigned LIMIT_CYCLES = 64'd6000000;

    localparam logic [PROTO_W-1:0]   PROTO_UDP      = 8'd17;
    localparam logic [PROTO_W-1:0]   PROTO_RESERVED = 8'd255;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI   = 8'd255;

    typedef enum logic {ROW_PKT, ROW_CFG} row_kind_e;

    typedef struct packed {
        logic [ADDR_W-1:0]  src;
        logic [PORT_W-1:0]  port;
        logic [PROTO_W-1:0] proto;
        logic               syn;
        logic [TIME_W-1:0]  stamp;
    } pkt_hdr_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  src;
        logic [CNT_W-1:0]   pkts;
        logic [SHOWN_W-1:0] ports;
        logic [CNT_W-1:0]   syns;
        logic               flood;
        logic               scan;
        logic               syn_hi;
        logic               untracked;
    } verdict_t;

    typedef struct packed {
        row_kind_e             kind;
        pkt_hdr_t              hdr;
        logic                  typed;
        verdict_t              want;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit                trk_valid  [SOURCES];
    logic [ADDR_W-1:0] trk_addr   [SOURCES];
    logic [TIME_W-1:0] trk_start  [SOURCES];
    logic [CNT_W-1:0]  trk_pkts   [SOURCES];
    logic [CNT_W-1:0]  trk_syns   [SOURCES];
    int unsigned       trk_nports [SOURCES];
    logic [PORT_W-1:0] trk_ports  [SOURCES][PORT_SLOTS];

    logic [CNT_W-1:0]   lim_flood;
    logic [SHOWN_W-1:0] lim_ports;
    logic [CNT_W-1:0]   lim_syns;
    logic [TIME_W-1:0]  win_len;

    verdict_t          pending_verdicts[$];
    stim_row_t         dir_rows[$];
    logic [ADDR_W-1:0] src_pool [POOL_SIZE];
    logic [TIME_W-1:0] now_tick;
    int unsigned       bad_count;
    bit                rx_free;
    bit                hold_req;
    longint unsigned   cycle_count;

    per_source_tcp_anomaly_detector_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic track_packet(input pkt_hdr_t h, output bit emits, output verdict_t v);
        int                e;
        int                k;
        bit                seen;
        logic [TIME_W-1:0] age;
        v      = '0;
        v.src  = h.src;
        emits  = 1'b0;
        e      = -1;
        if (h.proto == IPPROTO_TCP)
        begin
            emits = 1'b1;
            for (k = 0; k < SOURCES; k++)
                if (e < 0 && trk_valid[k] && trk_addr[k] == h.src)
                    e = k;
            for (k = 0; k < SOURCES; k++)
            begin
                if (e < 0 && !trk_valid[k])
                begin
                    e             = k;
                    trk_valid[k]  = 1'b1;
                    trk_addr[k]   = h.src;
                    trk_start[k]  = h.stamp;
                    trk_pkts[k]   = '0;
                    trk_syns[k]   = '0;
                    trk_nports[k] = 0;
                end
            end
            if (e < 0)
                v.untracked = 1'b1;
            else
            begin
                age = h.stamp - trk_start[e];
                if (age >= win_len)
                begin
                    trk_start[e]  = h.stamp;
                    trk_pkts[e]   = '0;
                    trk_syns[e]   = '0;
                    trk_nports[e] = 0;
                end
                if (trk_pkts[e] != CNT_MAX)
                    trk_pkts[e] = trk_pkts[e] + 1'b1;
                if (h.syn && trk_syns[e] != CNT_MAX)
                    trk_syns[e] = trk_syns[e] + 1'b1;
                seen = 1'b0;
                for (k = 0; k < trk_nports[e]; k++)
                    if (trk_ports[e][k] == h.port)
                        seen = 1'b1;
                if (!seen && trk_nports[e] < PORT_SLOTS)
                begin
                    trk_ports[e][trk_nports[e]] = h.port;
                    trk_nports[e] = trk_nports[e] + 1;
                end
                v.pkts   = trk_pkts[e];
                v.ports  = (trk_nports[e] > 63) ? SHOWN_W'(63) : SHOWN_W'(trk_nports[e]);
                v.syns   = trk_syns[e];
                v.flood  = trk_pkts[e] > lim_flood;
                v.scan   = trk_nports[e] > lim_ports;
                v.syn_hi = trk_syns[e] > lim_syns;
            end
        end
    endtask

    function automatic stim_row_t pkt_row(input logic [ADDR_W-1:0] src,
                                          input logic [PORT_W-1:0] port,
                                          input logic [PROTO_W-1:0] proto,
                                          input logic syn, input logic [TIME_W-1:0] stamp);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_PKT;
        r.hdr  = '{src, port, proto, syn, stamp};
        return r;
    endfunction

    // flags: [0] flood, [1] scan, [2] syn, [3] untracked
    function automatic stim_row_t tcp_row(input logic [ADDR_W-1:0] src,
                                          input logic [PORT_W-1:0] port, input logic syn,
                                          input logic [TIME_W-1:0] stamp,
                                          input logic [CNT_W-1:0] pkts,
                                          input logic [SHOWN_W-1:0] ports,
                                          input logic [CNT_W-1:0] syns,
                                          input logic [3:0] flags);
        stim_row_t r;
        r                = pkt_row(src, port, IPPROTO_TCP, syn, stamp);
        r.typed          = 1'b1;
        r.want.src       = src;
        r.want.pkts      = pkts;
        r.want.ports     = ports;
        r.want.syns      = syns;
        r.want.flood     = flags[0];
        r.want.scan      = flags[1];
        r.want.syn_hi    = flags[2];
        r.want.untracked = flags[3];
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_FLOOD_THR: lim_flood = val[CNT_W-1:0];
            REG_PORT_THR:  lim_ports = val[SHOWN_W-1:0];
            REG_SYN_THR:   lim_syns  = val[CNT_W-1:0];
            REG_WINDOW:    win_len   = val;
            default:       ;
        endcase
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] flood, input logic [CFG_DATA_W-1:0] ports,
                                input logic [CFG_DATA_W-1:0] syns, input logic [CFG_DATA_W-1:0] window);
        apply_reg(REG_FLOOD_THR, flood);
        apply_reg(REG_PORT_THR, ports);
        apply_reg(REG_SYN_THR, syns);
        apply_reg(REG_WINDOW, window);
        apply_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle;
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_pkt(input pkt_hdr_t h, input bit typed, input verdict_t want);
        bit       emits;
        verdict_t v;
        s_axis_tdata  <= {h.stamp, h.port, h.src};
        s_axis_tuser  <= {h.syn, h.proto};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_packet(h, emits, v);
        if (emits)
            pending_verdicts.push_back(typed ? want : v);
    endtask

    task automatic sender_gap;
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 70);
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [TIME_W-1:0] tick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return '0;
        else if (r < 80)
            return $urandom_range(1, 30);
        else if (r < 97)
            return $urandom_range(0, 3000);
        return $urandom;
    endfunction

    task automatic emit_tcp(input logic [ADDR_W-1:0] src, input logic [PORT_W-1:0] port,
                            input bit syn);
        pkt_hdr_t    h;
        int unsigned p;
        if ($urandom_range(0, 9) == 0)
        begin
            p = $urandom_range(0, 254);
            if (p >= IPPROTO_TCP)
                p++;
            now_tick = now_tick + tick_step();
            h = '{src, PORT_W'($urandom), PROTO_W'(p), 1'($urandom), now_tick};
            send_pkt(h, 1'b0, '0);
            sender_gap();
        end
        now_tick = now_tick + tick_step();
        h = '{src, port, IPPROTO_TCP, syn, now_tick};
        send_pkt(h, 1'b0, '0);
        sender_gap();
    endtask

    task automatic random_phase(input bit sweep);
        int                done;
        int                len;
        int                r;
        int                j;
        logic [ADDR_W-1:0] src;
        logic [PORT_W-1:0] base;
        done = 0;
        if (sweep)
        begin
            for (j = 0; j < POOL_SIZE; j++)
                emit_tcp(src_pool[j], PORT_W'($urandom), 1'($urandom));
            done = POOL_SIZE;
        end
        while (done < PHASE_ITEMS)
        begin
            r    = $urandom_range(0, 99);
            src  = ($urandom_range(0, 24) == 0) ? ADDR_W'($urandom)
                                                : src_pool[$urandom_range(0, POOL_SIZE - 1)];
            base = $urandom;
            if (r < 35)
            begin
                len = $urandom_range(8, 40);
                for (j = 0; j < len; j++)
                    emit_tcp(src, base + PORT_W'(j), $urandom_range(0, 3) == 0);
                done += len;
            end
            else if (r < 65)
            begin
                len = $urandom_range(5, 25);
                for (j = 0; j < len; j++)
                    emit_tcp(src, base + PORT_W'($urandom_range(0, 2)),
                             $urandom_range(0, 9) != 0);
                done += len;
            end
            else
            begin
                emit_tcp(src, PORT_W'($urandom), 1'($urandom));
                done++;
            end
        end
        wait_idle();
    endtask

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            bad_count++;
            if (bad_count <= MAX_REPORTS)
                $display("mismatch %s: expected %0h, got %0h", what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        verdict_t got;
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.src       = m_axis_tdata[31:0];
            got.pkts      = m_axis_tdata[47:32];
            got.ports     = m_axis_tdata[53:48];
            got.syns      = m_axis_tdata[69:54];
            got.flood     = m_axis_tuser[0];
            got.scan      = m_axis_tuser[1];
            got.syn_hi    = m_axis_tuser[2];
            got.untracked = m_axis_tuser[3];
            if (pending_verdicts.size() == 0)
            begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("unexpected result for source %h", got.src);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                check_field("source_echo", want.src, got.src);
                check_field("packets_in_window", want.pkts, got.pkts);
                check_field("distinct_ports", want.ports, got.ports);
                check_field("syns_in_window", want.syns, got.syns);
                check_field("flood_alert", want.flood, got.flood);
                check_field("scan_alert", want.scan, got.scan);
                check_field("syn_alert", want.syn_hi, got.syn_hi);
                check_field("untracked", want.untracked, got.untracked);
            end
        end
    end

    initial
    begin : receiver
        int n;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_free)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 99) < 60)
            begin
                m_axis_tready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(20, 60);
                repeat (n) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("per_source_tcp_anomaly_detector_unit test failed");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t row;
        pkt_hdr_t  hot;
        int        i;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rx_free       = 1'b0;
        hold_req      = 1'b0;
        bad_count     = 0;
        now_tick      = '0;
        lim_flood     = FLOOD_THR_RST;
        lim_ports     = PORT_THR_RST;
        lim_syns      = SYN_THR_RST;
        win_len       = WINDOW_RST;
        for (i = 0; i < SOURCES; i++)
        begin
            trk_valid[i]  = 1'b0;
            trk_addr[i]   = '0;
            trk_start[i]  = '0;
            trk_pkts[i]   = '0;
            trk_syns[i]   = '0;
            trk_nports[i] = 0;
        end

        dir_rows.push_back(tcp_row(32'h0, 16'h0, 1'b0, 32'd0, 16'd1, 6'd1, 16'd0, 4'b0000));
        dir_rows.push_back(tcp_row(32'h0, 16'hFFFF, 1'b1, 32'd5, 16'd2, 6'd2, 16'd1, 4'b0000));
        dir_rows.push_back(pkt_row(32'h0, 16'h0, PROTO_UDP, 1'b1, 32'd6));
        dir_rows.push_back(pkt_row(32'h0, 16'h0, PROTO_RESERVED, 1'b1, 32'd7));
        dir_rows.push_back(tcp_row(32'hFFFFFFFF, 16'hFFFF, 1'b1, 32'hFFFFFFFF,
                                   16'd1, 6'd1, 16'd1, 4'b0000));
        // wrapped timestamp, one tick short of the window
        dir_rows.push_back(tcp_row(32'hFFFFFFFF, 16'hFFFF, 1'b0, 32'h3E6,
                                   16'd2, 6'd1, 16'd1, 4'b0000));
        dir_rows.push_back(tcp_row(32'hFFFFFFFF, 16'h1, 1'b0, 32'h3E7,
                                   16'd1, 6'd1, 16'd0, 4'b0000));
        dir_rows.push_back(tcp_row(32'h0, 16'h0, 1'b0, 32'd1004, 16'd1, 6'd1, 16'd0, 4'b0000));
        dir_rows.push_back(cfg_row(REG_FLOOD_THR, 32'd0));
        dir_rows.push_back(cfg_row(REG_PORT_THR, 32'd0));
        dir_rows.push_back(cfg_row(REG_SYN_THR, 32'd0));
        dir_rows.push_back(tcp_row(32'h0, 16'd5, 1'b1, 32'd1005, 16'd2, 6'd2, 16'd1, 4'b0111));
        dir_rows.push_back(cfg_row(REG_SPARE_LO, 32'hFFFF));
        dir_rows.push_back(cfg_row(REG_SPARE_HI, 32'h0));
        dir_rows.push_back(cfg_row(REG_PORT_THR, 32'hFFFFFFC1));
        dir_rows.push_back(tcp_row(32'h0, 16'd5, 1'b0, 32'd1006, 16'd3, 6'd2, 16'd1, 4'b0111));
        dir_rows.push_back(cfg_row(REG_WINDOW, 32'd0));
        dir_rows.push_back(tcp_row(32'h0, 16'd7, 1'b0, 32'd1006, 16'd1, 6'd1, 16'd0, 4'b0001));
        dir_rows.push_back(tcp_row(32'h0, 16'd7, 1'b0, 32'd1006, 16'd1, 6'd1, 16'd0, 4'b0001));
        dir_rows.push_back(tcp_row(32'h0A000001, 16'd7, 1'b1, 32'd1006,
                                   16'd1, 6'd1, 16'd1, 4'b0101));
        dir_rows.push_back(cfg_row(REG_FLOOD_THR, 32'hFFFF));
        dir_rows.push_back(cfg_row(REG_PORT_THR, 32'd32));
        dir_rows.push_back(cfg_row(REG_SYN_THR, 32'hFFFF));
        dir_rows.push_back(cfg_row(REG_WINDOW, 32'hFFFFFFFF));
        dir_rows.push_back(tcp_row(32'h0A000001, 16'h8000, 1'b1, 32'h80000000,
                                   16'd2, 6'd2, 16'd2, 4'b0000));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
            begin
                wait_idle();
                apply_reg(row.reg_idx, row.reg_val);
                cfg_valid <= 1'b0;
            end
            else
            begin
                send_pkt(row.hdr, row.typed, row.want);
                sender_gap();
            end
        end

        // one source, one port, one instant: drive both counters into saturation
        wait_idle();
        program_regs(32'hFFFE, 32'd1, 32'hFFFE, 32'hFFFFFFFF);
        rx_free = 1'b1;
        hot = '{32'h0, 16'h1234, IPPROTO_TCP, 1'b1, 32'd1005};
        repeat (SAT_ITEMS) send_pkt(hot, 1'b0, '0);
        rx_free = 1'b0;
        wait_idle();

        src_pool[0] = 32'h0;
        src_pool[1] = 32'hFFFFFFFF;
        src_pool[2] = 32'h0A000001;
        for (i = 3; i < POOL_SIZE; i++)
            src_pool[i] = $urandom;
        now_tick = $urandom;

        program_regs(32'd20, 32'd8, 32'd10, 32'd2000);
        hold_req = 1'b1;
        random_phase(1'b1);
        program_regs(32'd0, 32'd0, 32'd0, 32'd1);
        random_phase(1'b0);
        program_regs(32'hFFFF, 32'd32, 32'hFFFF, 32'hFFFFFFFF);
        random_phase(1'b0);
        program_regs($urandom_range(0, 40), $urandom_range(0, 32), $urandom_range(0, 20),
                     $urandom_range(50, 5000));
        random_phase(1'b0);
        program_regs($urandom, $urandom, $urandom, $urandom);
        random_phase(1'b0);

        if (bad_count == 0)
            $display("per_source_tcp_anomaly_detector_unit test passed");
        else
            $display("per_source_tcp_anomaly_detector_unit test failed");
        $finish;
    end

endmodule
